// ===== hdl/tlnh_pkg.sv =====
`timescale 1ns / 1ps

package tlnh_pkg;

    // Default sizing of the table.
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int VALUE_BITS_DEF    = 16;

    // Fixed field widths of the two channels.
    localparam int FUNC_W   = 2;
    localparam int CHAR_W   = 7;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 3;

    // Operation codes; the fourth code is reserved.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK              = 3'd0,
        ST_NOT_FOUND       = 3'd1,
        ST_CONFLICTED      = 3'd2,
        ST_DISPLACED_TAKEN = 3'd3,
        ST_NEW_TAKEN       = 3'd4
    } status_t;

    // State of a first-level slot.
    typedef enum logic [1:0] {
        MARK_EMPTY    = 2'd0,
        MARK_OCCUPIED = 2'd1,
        MARK_CONFLICT = 2'd2
    } mark_t;

    // Table sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK1,
        S_CHECK2,
        S_WRITE2,
        S_RESP
    } state_t;

    // Command from the sequencer to the hash unit.
    typedef struct packed {
        logic start;
        logic last;
    } hash_cmd_t;

endpackage

// ===== hdl/two_level_name_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Channel | Ports                                                        | Direction
// --------+--------------------------------------------------------------+----------
// input   | s_valid s_ready s_func s_name_char s_last_char s_entry_value | in
// result  | m_valid m_ready m_status m_read_value                        | out
//
// A character beat forms both sums, then a reciprocal quotient, then a corrected remainder.
// On a last character a lookup or an insert goes through read, check and result; an insert
// that displaces also needs a second read and two writes through the second level's port.
// Clear, and the pass after reset, sweep every entry of both memories with s_ready low.
// A result waits in the output register while new character beats are taken; only the
// next result stalls on m_ready, and s_ready stays low until the waiting one leaves.

module two_level_name_hash_table_unit #(
    parameter int TABLE_ENTRIES = tlnh_pkg::TABLE_ENTRIES_DEF,
    parameter int VALUE_BITS    = tlnh_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [tlnh_pkg::FUNC_W-1:0]   s_func,
    input  logic [tlnh_pkg::CHAR_W-1:0]   s_name_char,
    input  logic                          s_last_char,
    input  logic [tlnh_pkg::DATA_W-1:0]   s_entry_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [tlnh_pkg::STATUS_W-1:0] m_status,
    output logic [tlnh_pkg::DATA_W-1:0]   m_read_value
);

    localparam int HB  = $clog2(TABLE_ENTRIES);
    localparam int VW  = (VALUE_BITS < tlnh_pkg::DATA_W) ? VALUE_BITS : tlnh_pkg::DATA_W;
    localparam int A_W = 2 + HB + VW;
    localparam int B_W = 1 + VW;
    localparam logic [HB-1:0] IDX_LAST = HB'(TABLE_ENTRIES - 1);

    tlnh_pkg::state_t state_reg, state_next;
    logic [HB-1:0]    clr_idx_reg, clr_idx_next;
    logic             clr_resp_reg, clr_resp_next;
    logic             last_reg, last_next;
    logic [tlnh_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [VW-1:0]    value_reg, value_next;
    logic [HB-1:0]    h1_reg, h1_next;
    logic [HB-1:0]    h2_reg, h2_next;
    logic [HB-1:0]    d_reg, d_next;
    logic [VW-1:0]    old_value_reg, old_value_next;
    logic             new_used_reg, new_used_next;
    logic [tlnh_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]    res_value_reg, res_value_next;
    logic             m_valid_reg, m_valid_next;
    logic [tlnh_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [tlnh_pkg::DATA_W-1:0]   m_read_value_reg, m_read_value_next;

    tlnh_pkg::hash_cmd_t hash_cmd;
    logic                hash_done;
    logic [HB-1:0]       hash_h1;
    logic [HB-1:0]       hash_h2;

    logic           a_we, a_re, b_we, b_re;
    logic [HB-1:0]  a_waddr, a_raddr, b_waddr, b_raddr;
    logic [A_W-1:0] a_wdata, a_rdata;
    logic [B_W-1:0] b_wdata, b_rdata;

    tlnh_pkg::mark_t a_mark;
    logic [HB-1:0]   a_sh2;
    logic [VW-1:0]   a_value;
    logic            b_used;
    logic [VW-1:0]   b_value;

    // Running hashes.
    tlnh_hash #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_hash (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (hash_cmd),
        .char_in(s_name_char),
        .done   (hash_done),
        .h1     (hash_h1),
        .h2     (hash_h2)
    );

    // First level: mark, stored second hash and value per slot.
    tlnh_ram #(
        .DEPTH(TABLE_ENTRIES),
        .WIDTH(A_W)
    ) u_first (
        .aclk (aclk),
        .we   (a_we),
        .waddr(a_waddr),
        .wdata(a_wdata),
        .re   (a_re),
        .raddr(a_raddr),
        .rdata(a_rdata)
    );

    // Second level: used flag and value per slot.
    tlnh_ram #(
        .DEPTH(TABLE_ENTRIES),
        .WIDTH(B_W)
    ) u_second (
        .aclk (aclk),
        .we   (b_we),
        .waddr(b_waddr),
        .wdata(b_wdata),
        .re   (b_re),
        .raddr(b_raddr),
        .rdata(b_rdata)
    );

    // Unpack the memory words.
    assign a_mark  = tlnh_pkg::mark_t'(a_rdata[A_W-1 -: 2]);
    assign a_sh2   = a_rdata[VW +: HB];
    assign a_value = a_rdata[VW-1:0];
    assign b_used  = b_rdata[VW];
    assign b_value = b_rdata[VW-1:0];

    assign s_ready      = (state_reg == tlnh_pkg::S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;

    // Sequencer: next state, memory accesses and result.
    always_comb begin
        state_next        = state_reg;
        clr_idx_next      = clr_idx_reg;
        clr_resp_next     = clr_resp_reg;
        last_next         = last_reg;
        func_next         = func_reg;
        value_next        = value_reg;
        h1_next           = h1_reg;
        h2_next           = h2_reg;
        d_next            = d_reg;
        old_value_next    = old_value_reg;
        new_used_next     = new_used_reg;
        res_status_next   = res_status_reg;
        res_value_next    = res_value_reg;
        m_valid_next      = m_valid_reg;
        m_status_next     = m_status_reg;
        m_read_value_next = m_read_value_reg;
        hash_cmd          = '0;
        a_we              = 1'b0;
        a_waddr           = h1_reg;
        a_wdata           = '0;
        a_re              = 1'b0;
        a_raddr           = h1_reg;
        b_we              = 1'b0;
        b_waddr           = h2_reg;
        b_wdata           = '0;
        b_re              = 1'b0;
        b_raddr           = h2_reg;

        // The waiting result leaves once it is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            tlnh_pkg::S_CLEAR: begin
                a_we         = 1'b1;
                a_waddr      = clr_idx_reg;
                a_wdata      = {tlnh_pkg::MARK_EMPTY, {(HB + VW){1'b0}}};
                b_we         = 1'b1;
                b_waddr      = clr_idx_reg;
                b_wdata      = '0;
                clr_idx_next = clr_idx_reg + HB'(1);
                if (clr_idx_reg == IDX_LAST) begin
                    clr_idx_next  = '0;
                    clr_resp_next = 1'b0;
                    if (clr_resp_reg) begin
                        res_status_next = tlnh_pkg::ST_OK;
                        res_value_next  = '0;
                        state_next      = tlnh_pkg::S_RESP;
                    end else begin
                        state_next = tlnh_pkg::S_IDLE;
                    end
                end
            end
            tlnh_pkg::S_IDLE: begin
                if (s_valid) begin
                    hash_cmd.start = 1'b1;
                    hash_cmd.last  = s_last_char;
                    last_next      = s_last_char;
                    func_next      = s_func;
                    value_next     = VW'(s_entry_value);
                    state_next     = tlnh_pkg::S_HASH;
                end
            end
            tlnh_pkg::S_HASH: begin
                if (hash_done) begin
                    h1_next = hash_h1;
                    h2_next = hash_h2;
                    if (!last_reg) begin
                        state_next = tlnh_pkg::S_IDLE;
                    end else begin
                        case (func_reg)
                            tlnh_pkg::FUNC_LOOKUP, tlnh_pkg::FUNC_INSERT: begin
                                state_next = tlnh_pkg::S_READ;
                            end
                            tlnh_pkg::FUNC_CLEAR: begin
                                clr_resp_next = 1'b1;
                                state_next    = tlnh_pkg::S_CLEAR;
                            end
                            default: begin
                                res_status_next = tlnh_pkg::ST_NOT_FOUND;
                                res_value_next  = '0;
                                state_next      = tlnh_pkg::S_RESP;
                            end
                        endcase
                    end
                end
            end
            tlnh_pkg::S_READ: begin
                a_re       = 1'b1;
                b_re       = 1'b1;
                state_next = tlnh_pkg::S_CHECK1;
            end
            tlnh_pkg::S_CHECK1: begin
                res_value_next = '0;
                if (func_reg == tlnh_pkg::FUNC_LOOKUP) begin
                    res_status_next = tlnh_pkg::ST_NOT_FOUND;
                    state_next      = tlnh_pkg::S_RESP;
                    case (a_mark)
                        tlnh_pkg::MARK_OCCUPIED: begin
                            res_status_next = tlnh_pkg::ST_OK;
                            res_value_next  = a_value;
                        end
                        tlnh_pkg::MARK_CONFLICT: begin
                            if (b_used) begin
                                res_status_next = tlnh_pkg::ST_OK;
                                res_value_next  = b_value;
                            end
                        end
                        default: begin
                        end
                    endcase
                end else begin
                    case (a_mark)
                        tlnh_pkg::MARK_EMPTY: begin
                            a_we            = 1'b1;
                            a_wdata         = {tlnh_pkg::MARK_OCCUPIED, h2_reg, value_reg};
                            res_status_next = tlnh_pkg::ST_OK;
                            state_next      = tlnh_pkg::S_RESP;
                        end
                        tlnh_pkg::MARK_OCCUPIED: begin
                            // Keep what the displacement needs, fetch its slot.
                            new_used_next  = b_used;
                            old_value_next = a_value;
                            d_next         = a_sh2;
                            b_re           = 1'b1;
                            b_raddr        = a_sh2;
                            state_next     = tlnh_pkg::S_CHECK2;
                        end
                        default: begin
                            res_status_next = tlnh_pkg::ST_CONFLICTED;
                            state_next      = tlnh_pkg::S_RESP;
                        end
                    endcase
                end
            end
            tlnh_pkg::S_CHECK2: begin
                res_value_next = '0;
                if (b_used) begin
                    res_status_next = tlnh_pkg::ST_DISPLACED_TAKEN;
                    state_next      = tlnh_pkg::S_RESP;
                end else if (new_used_reg || (d_reg == h2_reg)) begin
                    res_status_next = tlnh_pkg::ST_NEW_TAKEN;
                    state_next      = tlnh_pkg::S_RESP;
                end else begin
                    // Move the old occupant down and mark the slot conflicted.
                    b_we       = 1'b1;
                    b_waddr    = d_reg;
                    b_wdata    = {1'b1, old_value_reg};
                    a_we       = 1'b1;
                    a_wdata    = {tlnh_pkg::MARK_CONFLICT, d_reg, old_value_reg};
                    state_next = tlnh_pkg::S_WRITE2;
                end
            end
            tlnh_pkg::S_WRITE2: begin
                b_we            = 1'b1;
                b_wdata         = {1'b1, value_reg};
                res_status_next = tlnh_pkg::ST_OK;
                res_value_next  = '0;
                state_next      = tlnh_pkg::S_RESP;
            end
            tlnh_pkg::S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_read_value_next = tlnh_pkg::DATA_W'(res_value_reg);
                    state_next        = tlnh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = tlnh_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers; reset starts the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tlnh_pkg::S_CLEAR;
            clr_idx_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        last_reg         <= last_next;
        func_reg         <= func_next;
        value_reg        <= value_next;
        h1_reg           <= h1_next;
        h2_reg           <= h2_next;
        d_reg            <= d_next;
        old_value_reg    <= old_value_next;
        new_used_reg     <= new_used_next;
        res_status_reg   <= res_status_next;
        res_value_reg    <= res_value_next;
        m_status_reg     <= m_status_next;
        m_read_value_reg <= m_read_value_next;
    end

`ifndef SYNTHESIS
    // The hash unit only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hash_done |-> (state_reg == tlnh_pkg::S_HASH))
        else $error("hash result outside the hash wait state");

    // Only a successful lookup returns a nonzero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != tlnh_pkg::ST_OK)) |-> (m_read_value_reg == '0))
        else $error("nonzero value with a failing status");

    // The table is never written while the block waits for a beat.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!a_we && !b_we))
        else $error("table written while idle");

    // The second insert write only follows a passed displacement check.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == tlnh_pkg::S_WRITE2) |-> ($past(state_reg) == tlnh_pkg::S_CHECK2))
        else $error("second-level write without displacement check");
`endif

endmodule

// ===== hdl/tlnh_ram.sv =====
`timescale 1ns / 1ps

module tlnh_ram #(
    parameter int DEPTH = tlnh_pkg::TABLE_ENTRIES_DEF,
    parameter int WIDTH = tlnh_pkg::DATA_W,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/tlnh_hash.sv =====
`timescale 1ns / 1ps

module tlnh_hash #(
    parameter int TABLE_ENTRIES = tlnh_pkg::TABLE_ENTRIES_DEF,
    localparam int HB = $clog2(TABLE_ENTRIES)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  tlnh_pkg::hash_cmd_t         cmd,
    input  logic [tlnh_pkg::CHAR_W-1:0] char_in,
    output logic                        done,
    output logic [HB-1:0]               h1,
    output logic [HB-1:0]               h2
);

    // A raw sum stays below 128 * TABLE_ENTRIES, so XW bits hold it.
    localparam int XW = HB + tlnh_pkg::CHAR_W;
    localparam int PW = 2 * XW;
    localparam logic [XW-1:0] RECIP    = XW'((64'd1 << XW) / TABLE_ENTRIES);
    localparam logic [XW-1:0] MODULUS  = XW'(TABLE_ENTRIES);
    localparam logic [HB-1:0] POS_LAST  = HB'(TABLE_ENTRIES - 1);
    localparam logic [HB-1:0] POS_FIRST = HB'(1);

    logic [HB-1:0] ps_reg;
    logic [HB-1:0] ws_reg;
    logic [HB-1:0] pos_reg;
    logic [XW-1:0] px_reg;
    logic [XW-1:0] wx_reg;
    logic [XW-1:0] qp_reg;
    logic [XW-1:0] qw_reg;
    logic          last_reg;
    logic          st1_reg;
    logic          st2_reg;

    logic [XW-1:0] wprod;
    logic [PW-1:0] pm;
    logic [PW-1:0] wm;
    logic [XW-1:0] pr;
    logic [XW-1:0] wr;
    logic [XW-1:0] pr_fix;
    logic [XW-1:0] wr_fix;

    // Stage 0 forms the raw sums, stage 1 estimates the quotient by a
    // reciprocal, stage 2 subtracts and corrects the remainder once.
    always_comb begin
        wprod  = XW'(char_in) * XW'(pos_reg);
        pm     = PW'(px_reg) * PW'(RECIP);
        wm     = PW'(wx_reg) * PW'(RECIP);
        pr     = px_reg - qp_reg * MODULUS;
        wr     = wx_reg - qw_reg * MODULUS;
        pr_fix = (pr >= MODULUS) ? pr - MODULUS : pr;
        wr_fix = (wr >= MODULUS) ? wr - MODULUS : wr;
    end

    assign done = st2_reg;
    assign h1   = pr_fix[HB-1:0];
    assign h2   = wr_fix[HB-1:0];

    // Stage flags and the running hash state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_reg <= 1'b0;
            st2_reg <= 1'b0;
            ps_reg  <= '0;
            ws_reg  <= '0;
            pos_reg <= POS_FIRST;
        end else begin
            st1_reg <= cmd.start;
            st2_reg <= st1_reg;
            if (cmd.start) begin
                if (cmd.last) begin
                    pos_reg <= POS_FIRST;
                end else if (pos_reg == POS_LAST) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + HB'(1);
                end
            end
            if (st2_reg) begin
                ps_reg <= last_reg ? '0 : h1;
                ws_reg <= last_reg ? '0 : h2;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            px_reg   <= XW'(char_in) + XW'(ps_reg);
            wx_reg   <= wprod + XW'(ws_reg);
            last_reg <= cmd.last;
        end
        if (st1_reg) begin
            qp_reg <= pm[PW-1:XW];
            qw_reg <= wm[PW-1:XW];
        end
    end

endmodule
